// ===== hw/rtl/rsp_pkg.sv =====
// ----------------------------------------------------------------------------
// rsp_pkg
// Shared types, constants and helper functions of the point projector.
// ----------------------------------------------------------------------------
package rsp_pkg;

    localparam int COORD_FRAC_BITS = 16;
    localparam int SPHERE_FRAC     = 30;
    localparam int TRIG_FRAC       = 16;
    localparam int TRIG_ONE        = 65536;
    localparam int DIV_STEPS       = SPHERE_FRAC + 2;
    localparam int CFG_IDX_W       = 3;
    localparam int CFG_DATA_W      = 32;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_CENTER_X = 3'd0,
        CFG_CENTER_Y = 3'd1,
        CFG_RADIUS   = 3'd2,
        CFG_COS_X    = 3'd3,
        CFG_SIN_X    = 3'd4,
        CFG_COS_Y    = 3'd5,
        CFG_SIN_Y    = 3'd6
    } t_cfg_idx;

    typedef struct packed {
        logic signed [31:0] point_re;
        logic signed [31:0] point_im;
        logic               point_finite;
        logic               batch_last;
    } t_in_word;

    typedef struct packed {
        logic signed [31:0] screen_x;
        logic signed [31:0] screen_y;
        logic               front_facing;
        logic               result_valid;
        logic               batch_end;
    } t_out_word;

    typedef struct packed {
        logic signed [31:0] ctr_x;
        logic signed [31:0] ctr_y;
        logic        [30:0] radius;
        logic signed [17:0] cos_x;
        logic signed [17:0] sin_x;
        logic signed [17:0] cos_y;
        logic signed [17:0] sin_y;
    } t_cfg;

    // sideband that rides along the divider
    typedef struct packed {
        logic finite;
        logic last;
        logic neg_re;
        logic neg_im;
        logic z_pos;
    } t_tag;

    typedef struct packed {
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [31:0] z;
        logic               finite;
        logic               last;
    } t_sphere;

    typedef struct packed {
        logic signed [33:0] rx;
        logic signed [33:0] ry;
        logic               front;
        logic               finite;
        logic               last;
    } t_rot;

    typedef struct packed {
        logic        q_bit;
        logic [63:0] rem;
    } t_div_step;

    // one restoring step; the first step compares without the shift
    function automatic t_div_step div_step(input logic [63:0] rem,
                                           input logic [63:0] den,
                                           input logic        first);
        logic [64:0] t;
        t_div_step   r;
        t       = first ? {1'b0, rem} : {rem, 1'b0};
        r.q_bit = (t >= {1'b0, den});
        r.rem   = r.q_bit ? 64'(t - {1'b0, den}) : t[63:0];
        return r;
    endfunction

    // saturate a trig value to [-1.0, 1.0]
    function automatic logic signed [17:0] trig_clip(input logic [17:0] raw);
        logic signed [17:0] v;
        v = $signed(raw);
        if (v > 18'sd65536) begin
            return 18'sd65536;
        end else if (v < -18'sd65536) begin
            return -18'sd65536;
        end
        return v;
    endfunction

endpackage

// ===== hw/rtl/rsp_lift.sv =====
// ----------------------------------------------------------------------------
// rsp_lift
// Inverse stereographic lift: squares, denominator, three pipelined
// restoring dividers (one quotient bit per stage) and sign restore.
// ----------------------------------------------------------------------------
module rsp_lift #(
    parameter int FRAC_BITS = rsp_pkg::COORD_FRAC_BITS
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_adv,
    input  logic               i_valid,
    input  rsp_pkg::t_in_word  i_word,
    output logic               o_valid,
    output rsp_pkg::t_sphere   o_sph
);

    localparam int          NS   = rsp_pkg::DIV_STEPS;
    localparam logic [63:0] ONE2 = 64'd1 << (2 * FRAC_BITS);

    // stage 0: magnitudes
    logic          r_s0_valid;
    rsp_pkg::t_tag r_s0_tag;
    logic [31:0]   r_s0_are, r_s0_aim;
    // stage 1: squares
    logic          r_s1_valid;
    rsp_pkg::t_tag r_s1_tag;
    logic [31:0]   r_s1_are, r_s1_aim;
    logic [63:0]   r_s1_sq_re, r_s1_sq_im;
    // stage 2: r2
    logic          r_s2_valid;
    rsp_pkg::t_tag r_s2_tag;
    logic [31:0]   r_s2_are, r_s2_aim;
    logic [63:0]   r_s2_r2;
    // stage 3: numerators and denominator
    logic          r_s3_valid;
    rsp_pkg::t_tag r_s3_tag;
    rsp_pkg::t_tag n_s3_tag;
    logic [63:0]   r_s3_num [3];
    logic [63:0]   r_s3_den;
    // divider stages
    logic          r_dv_valid [NS];
    rsp_pkg::t_tag r_dv_tag   [NS];
    logic [63:0]   r_dv_den   [NS];
    logic [63:0]   r_dv_rem   [NS][3];
    logic [NS-1:0] r_dv_q     [NS][3];
    // output stage
    logic             r_out_valid;
    rsp_pkg::t_sphere r_out;

    logic [31:0] n_mag [3];
    logic        neg   [3];

    always_comb begin
        n_s3_tag       = r_s2_tag;
        n_s3_tag.z_pos = (r_s2_r2 >= ONE2);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s0_valid <= 1'b0;
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
            r_s3_valid <= 1'b0;
        end else if (i_adv) begin
            r_s0_valid <= i_valid;
            r_s1_valid <= r_s0_valid;
            r_s2_valid <= r_s1_valid;
            r_s3_valid <= r_s2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_s0_tag.finite <= i_word.point_finite;
            r_s0_tag.last   <= i_word.batch_last;
            r_s0_tag.neg_re <= i_word.point_re[31];
            r_s0_tag.neg_im <= i_word.point_im[31];
            r_s0_tag.z_pos  <= 1'b0;
            r_s0_are <= i_word.point_re[31] ? 32'(-i_word.point_re) : i_word.point_re;
            r_s0_aim <= i_word.point_im[31] ? 32'(-i_word.point_im) : i_word.point_im;

            r_s1_tag   <= r_s0_tag;
            r_s1_are   <= r_s0_are;
            r_s1_aim   <= r_s0_aim;
            r_s1_sq_re <= 64'(r_s0_are) * 64'(r_s0_are);
            r_s1_sq_im <= 64'(r_s0_aim) * 64'(r_s0_aim);

            r_s2_tag <= r_s1_tag;
            r_s2_are <= r_s1_are;
            r_s2_aim <= r_s1_aim;
            r_s2_r2  <= r_s1_sq_re + r_s1_sq_im;

            r_s3_tag    <= n_s3_tag;
            r_s3_num[0] <= 64'(r_s2_are) << (FRAC_BITS + 1);
            r_s3_num[1] <= 64'(r_s2_aim) << (FRAC_BITS + 1);
            r_s3_num[2] <= (r_s2_r2 >= ONE2) ? (r_s2_r2 - ONE2) : (ONE2 - r_s2_r2);
            r_s3_den    <= r_s2_r2 + ONE2;
        end
    end

    for (genvar k = 0; k < NS; k++) begin : g_step
        logic          valid_in;
        rsp_pkg::t_tag tag_in;
        logic [63:0]   den_in;
        if (k == 0) begin : g_first
            assign valid_in = r_s3_valid;
            assign tag_in   = r_s3_tag;
            assign den_in   = r_s3_den;
        end else begin : g_next
            assign valid_in = r_dv_valid[k-1];
            assign tag_in   = r_dv_tag[k-1];
            assign den_in   = r_dv_den[k-1];
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_dv_valid[k] <= 1'b0;
            end else if (i_adv) begin
                r_dv_valid[k] <= valid_in;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_adv) begin
                r_dv_tag[k] <= tag_in;
                r_dv_den[k] <= den_in;
            end
        end

        for (genvar l = 0; l < 3; l++) begin : g_lane
            logic [63:0]        rem_in;
            logic [NS-1:0]      q_in;
            rsp_pkg::t_div_step st;
            if (k == 0) begin : g_first
                assign rem_in = r_s3_num[l];
                assign q_in   = '0;
            end else begin : g_next
                assign rem_in = r_dv_rem[k-1][l];
                assign q_in   = r_dv_q[k-1][l];
            end
            assign st = rsp_pkg::div_step(rem_in, den_in, 1'(k == 0));

            always_ff @(posedge i_clk) begin
                if (i_adv) begin
                    r_dv_rem[k][l] <= st.rem;
                    r_dv_q[k][l]   <= {q_in[NS-2:0], st.q_bit};
                end
            end
        end
    end

    assign neg[0] = r_dv_tag[NS-1].neg_re;
    assign neg[1] = r_dv_tag[NS-1].neg_im;
    assign neg[2] = !r_dv_tag[NS-1].z_pos;

    // round half up on the extra quotient bit
    always_comb begin
        for (int l = 0; l < 3; l++) begin
            n_mag[l] = 32'(({1'b0, r_dv_q[NS-1][l]} + 33'd1) >> 1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_adv) begin
            r_out_valid <= r_dv_valid[NS-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_out.x      <= neg[0] ? $signed(-n_mag[0]) : $signed(n_mag[0]);
            r_out.y      <= neg[1] ? $signed(-n_mag[1]) : $signed(n_mag[1]);
            r_out.z      <= neg[2] ? $signed(-n_mag[2]) : $signed(n_mag[2]);
            r_out.finite <= r_dv_tag[NS-1].finite;
            r_out.last   <= r_dv_tag[NS-1].last;
        end
    end

    assign o_valid = r_out_valid;
    assign o_sph   = r_out;

endmodule

// ===== hw/rtl/rsp_rotate.sv =====
// ----------------------------------------------------------------------------
// rsp_rotate
// Rotation about y, then about x: products, sums and rounding each in a
// stage of their own.
// ----------------------------------------------------------------------------
module rsp_rotate (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_adv,
    input  logic              i_valid,
    input  rsp_pkg::t_sphere  i_sph,
    input  rsp_pkg::t_cfg     i_cfg,
    output logic              o_valid,
    output rsp_pkg::t_rot     o_rot
);

    logic [5:0] r_valid;
    logic [5:0][1:0] r_side;  // {finite, last}

    logic signed [49:0] r1_xc, r1_zs, r1_zc, r1_xs;
    logic signed [31:0] r1_y, r2_y, r3_y;
    logic signed [50:0] r2_rx, r2_fz;
    logic signed [33:0] r3_rx, r3_fz, r4_rx, r5_rx, r6_rx;
    logic signed [51:0] r4_yc, r4_fs, r4_ys, r4_fc;
    logic signed [52:0] r5_ry, r5_rz;
    logic signed [33:0] r6_ry;
    logic               r6_front;

    logic signed [50:0] n_rx_t, n_fz_t;
    logic signed [52:0] n_ry_t, n_rz_t;
    logic signed [36:0] n_rz;

    // ties away from zero: add half, less one when negative, then shift
    assign n_rx_t = r2_rx + (r2_rx[50] ? 51'sd32767 : 51'sd32768);
    assign n_fz_t = r2_fz + (r2_fz[50] ? 51'sd32767 : 51'sd32768);
    assign n_ry_t = r5_ry + (r5_ry[52] ? 53'sd32767 : 53'sd32768);
    assign n_rz_t = r5_rz + (r5_rz[52] ? 53'sd32767 : 53'sd32768);
    assign n_rz   = 37'(n_rz_t >>> rsp_pkg::TRIG_FRAC);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_adv) begin
            r_valid <= {r_valid[4:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_side <= {r_side[4:0], {i_sph.finite, i_sph.last}};

            r1_xc <= i_sph.x * i_cfg.cos_y;
            r1_zs <= i_sph.z * i_cfg.sin_y;
            r1_zc <= i_sph.z * i_cfg.cos_y;
            r1_xs <= i_sph.x * i_cfg.sin_y;
            r1_y  <= i_sph.y;

            r2_rx <= 51'(r1_xc) + 51'(r1_zs);
            r2_fz <= 51'(r1_zc) - 51'(r1_xs);
            r2_y  <= r1_y;

            r3_rx <= 34'(n_rx_t >>> rsp_pkg::TRIG_FRAC);
            r3_fz <= 34'(n_fz_t >>> rsp_pkg::TRIG_FRAC);
            r3_y  <= r2_y;

            r4_yc <= r3_y * i_cfg.cos_x;
            r4_fs <= r3_fz * i_cfg.sin_x;
            r4_ys <= r3_y * i_cfg.sin_x;
            r4_fc <= r3_fz * i_cfg.cos_x;
            r4_rx <= r3_rx;

            r5_ry <= 53'(r4_yc) - 53'(r4_fs);
            r5_rz <= 53'(r4_ys) + 53'(r4_fc);
            r5_rx <= r4_rx;

            r6_ry    <= 34'(n_ry_t >>> rsp_pkg::TRIG_FRAC);
            r6_front <= !n_rz[36];
            r6_rx    <= r5_rx;
        end
    end

    assign o_valid      = r_valid[5];
    assign o_rot.rx     = r6_rx;
    assign o_rot.ry     = r6_ry;
    assign o_rot.front  = r6_front;
    assign o_rot.finite = r_side[5][1];
    assign o_rot.last   = r_side[5][0];

endmodule

// ===== hw/rtl/rsp_canvas.sv =====
// ----------------------------------------------------------------------------
// rsp_canvas
// Scale by radius (split into two partial products), round, offset from
// the center and saturate. The last stage is the output register.
// ----------------------------------------------------------------------------
module rsp_canvas (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_adv,
    input  logic               i_valid,
    input  rsp_pkg::t_rot      i_rot,
    input  rsp_pkg::t_cfg      i_cfg,
    output logic               o_valid,
    output rsp_pkg::t_out_word o_word
);

    localparam logic signed [36:0] SAT_MAX = 37'sd2147483647;
    localparam logic signed [36:0] SAT_MIN = -37'sd2147483648;

    logic [3:0] r_valid;
    logic [2:0][2:0] r_side;  // {finite, last, front}

    logic signed [50:0] r7_xlo, r7_ylo;
    logic signed [49:0] r7_xhi, r7_yhi;
    logic signed [65:0] r8_px, r8_py;
    logic signed [35:0] r9_ox, r9_oy;
    rsp_pkg::t_out_word r_out;

    logic signed [16:0] rad_lo;
    logic signed [15:0] rad_hi;
    logic signed [65:0] n_tx, n_ty;
    logic signed [36:0] n_sx, n_sy;
    logic               n_ovf_x, n_ovf_y;

    assign rad_lo = $signed({1'b0, i_cfg.radius[15:0]});
    assign rad_hi = $signed({1'b0, i_cfg.radius[30:16]});

    assign n_tx = r8_px + (r8_px[65] ? 66'sd536870911 : 66'sd536870912);
    assign n_ty = r8_py + (r8_py[65] ? 66'sd536870911 : 66'sd536870912);

    assign n_sx    = 37'(i_cfg.ctr_x) + 37'(r9_ox);
    assign n_sy    = 37'(i_cfg.ctr_y) - 37'(r9_oy);
    assign n_ovf_x = (n_sx > SAT_MAX) || (n_sx < SAT_MIN);
    assign n_ovf_y = (n_sy > SAT_MAX) || (n_sy < SAT_MIN);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_adv) begin
            r_valid <= {r_valid[2:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_side <= {r_side[1:0], {i_rot.finite, i_rot.last, i_rot.front}};

            r7_xlo <= i_rot.rx * rad_lo;
            r7_xhi <= i_rot.rx * rad_hi;
            r7_ylo <= i_rot.ry * rad_lo;
            r7_yhi <= i_rot.ry * rad_hi;

            r8_px <= (66'(r7_xhi) <<< 16) + 66'(r7_xlo);
            r8_py <= (66'(r7_yhi) <<< 16) + 66'(r7_ylo);

            r9_ox <= 36'(n_tx >>> rsp_pkg::SPHERE_FRAC);
            r9_oy <= 36'(n_ty >>> rsp_pkg::SPHERE_FRAC);

            r_out.batch_end <= r_side[2][1];
            if (!r_side[2][2]) begin
                r_out.screen_x     <= '0;
                r_out.screen_y     <= '0;
                r_out.front_facing <= 1'b0;
                r_out.result_valid <= 1'b0;
            end else begin
                if (n_sx > SAT_MAX) begin
                    r_out.screen_x <= 32'sh7fffffff;
                end else if (n_sx < SAT_MIN) begin
                    r_out.screen_x <= 32'sh80000000;
                end else begin
                    r_out.screen_x <= 32'(n_sx);
                end
                if (n_sy > SAT_MAX) begin
                    r_out.screen_y <= 32'sh7fffffff;
                end else if (n_sy < SAT_MIN) begin
                    r_out.screen_y <= 32'sh80000000;
                end else begin
                    r_out.screen_y <= 32'(n_sy);
                end
                r_out.result_valid <= !(n_ovf_x || n_ovf_y);
                r_out.front_facing <= !(n_ovf_x || n_ovf_y) && r_side[2][0];
            end
        end
    end

    assign o_valid = r_valid[3];
    assign o_word  = r_out;

endmodule

// ===== hw/rtl/rotated_stereographic_point_projector_core.sv =====
// ----------------------------------------------------------------------------
// rotated_stereographic_point_projector_core
// Lifts complex points onto the unit sphere, rotates them and maps them
// onto canvas coordinates.
// ----------------------------------------------------------------------------
//  channel | direction | handshake                   | word
//  --------+-----------+-----------------------------+-----------------------
//  in      | input     | i_in_valid / o_in_ready     | i_in_data  (t_in_word)
//  out     | output    | o_out_valid / i_out_ready   | o_out_data (t_out_word)
//  cfg     | input     | i_cfg_we, no wait           | i_cfg_index, i_cfg_wdata
//
//  One word is accepted per cycle while the output is not stalled; the
//  pipe is the 32-stage restoring divider (one quotient bit per stage)
//  plus the squaring, rotation and canvas stages.
//  Reset clears all valid bits and loads the register defaults.
//  A stall at the output holds every stage at once, bubbles included,
//  and drops o_in_ready for that cycle.
// ----------------------------------------------------------------------------
module rotated_stereographic_point_projector_core #(
    parameter int COORD_FRAC_BITS = rsp_pkg::COORD_FRAC_BITS
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  rsp_pkg::t_in_word                 i_in_data,
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output rsp_pkg::t_out_word                o_out_data,
    input  logic                              i_cfg_we,
    input  logic [rsp_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [rsp_pkg::CFG_DATA_W-1:0]    i_cfg_wdata
);

    rsp_pkg::t_cfg    r_cfg;
    logic             adv;
    logic             lift_valid, rot_valid;
    rsp_pkg::t_sphere lift_sph;
    rsp_pkg::t_rot    rot;

    // advance the whole pipe unless the output word is stuck
    assign adv        = !o_out_valid || i_out_ready;
    assign o_in_ready = adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.ctr_x  <= '0;
            r_cfg.ctr_y  <= '0;
            r_cfg.radius <= 31'd65536;
            r_cfg.cos_x  <= 18'sd65536;
            r_cfg.sin_x  <= '0;
            r_cfg.cos_y  <= 18'sd65536;
            r_cfg.sin_y  <= '0;
        end else if (i_cfg_we) begin
            case (rsp_pkg::t_cfg_idx'(i_cfg_index))
                rsp_pkg::CFG_CENTER_X: r_cfg.ctr_x  <= $signed(i_cfg_wdata);
                rsp_pkg::CFG_CENTER_Y: r_cfg.ctr_y  <= $signed(i_cfg_wdata);
                rsp_pkg::CFG_RADIUS:   r_cfg.radius <= i_cfg_wdata[30:0];
                rsp_pkg::CFG_COS_X:    r_cfg.cos_x <= rsp_pkg::trig_clip(i_cfg_wdata[17:0]);
                rsp_pkg::CFG_SIN_X:    r_cfg.sin_x <= rsp_pkg::trig_clip(i_cfg_wdata[17:0]);
                rsp_pkg::CFG_COS_Y:    r_cfg.cos_y <= rsp_pkg::trig_clip(i_cfg_wdata[17:0]);
                rsp_pkg::CFG_SIN_Y:    r_cfg.sin_y <= rsp_pkg::trig_clip(i_cfg_wdata[17:0]);
                default: begin
                end
            endcase
        end
    end

    rsp_lift #(
        .FRAC_BITS (COORD_FRAC_BITS)
    ) u_lift (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (adv),
        .i_valid (i_in_valid),
        .i_word  (i_in_data),
        .o_valid (lift_valid),
        .o_sph   (lift_sph)
    );

    rsp_rotate u_rotate (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (adv),
        .i_valid (lift_valid),
        .i_sph   (lift_sph),
        .i_cfg   (r_cfg),
        .o_valid (rot_valid),
        .o_rot   (rot)
    );

    rsp_canvas u_canvas (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (adv),
        .i_valid (rot_valid),
        .i_rot   (rot),
        .i_cfg   (r_cfg),
        .o_valid (o_out_valid),
        .o_word  (o_out_data)
    );

endmodule

// ===== hw/rtl/rsp_checker.sv =====
// ----------------------------------------------------------------------------
// rsp_checker
// Port-level checks on the projector, attached by bind.
// ----------------------------------------------------------------------------
module rsp_checker (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            o_in_ready,
    input logic                            o_out_valid,
    input logic                            i_out_ready,
    input rsp_pkg::t_out_word              o_out_data
);

    // a stalled output word holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_data))
        else $error("output word changed under stall");

    // an empty output register never blocks the input
    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_out_valid |-> o_in_ready)
        else $error("input blocked with empty output");

    a_front_needs_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out_data.result_valid |-> !o_out_data.front_facing)
        else $error("front_facing set on invalid result");

    // an invalid result is either the zero word or a saturated one
    a_invalid_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out_data.result_valid |->
            (o_out_data.screen_x == 32'sd0 && o_out_data.screen_y == 32'sd0) ||
            o_out_data.screen_x == 32'sh7fffffff ||
            o_out_data.screen_x == 32'sh80000000 ||
            o_out_data.screen_y == 32'sh7fffffff ||
            o_out_data.screen_y == 32'sh80000000)
        else $error("invalid result neither cleared nor saturated");

    // the output register is empty right after reset
    a_no_phantom: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(!i_rst_n) |-> !o_out_valid)
        else $error("output valid right after reset");

endmodule

bind rotated_stereographic_point_projector_core rsp_checker u_rsp_checker (.*);

// ===== bench/tb_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Streams complex points through the projector under random handshake
// gaps and several register settings, and checks every output word against
// a fixed-point prediction of the sphere lift, rotation and canvas mapping.
// ----------------------------------------------------------------------------
module tb_top;

    localparam int LATENCY   = 47;
    localparam int WD_LIMIT  = 20000;
    localparam int N_RANDOM  = 1300;

    logic                                  i_clk = 1'b0;
    logic                                  i_rst_n = 1'b0;
    logic                                  i_in_valid = 1'b0;
    logic                                  o_in_ready;
    rsp_pkg::t_in_word                     i_in_data = '0;
    logic                                  o_out_valid;
    logic                                  i_out_ready = 1'b0;
    rsp_pkg::t_out_word                    o_out_data;
    logic                                  i_cfg_we = 1'b0;
    logic [rsp_pkg::CFG_IDX_W-1:0]         i_cfg_index = '0;
    logic [rsp_pkg::CFG_DATA_W-1:0]        i_cfg_wdata = '0;

    rotated_stereographic_point_projector_core dut (.*);

    always #5 i_clk = ~i_clk;

    // shadow copy of the projector registers
    logic signed [31:0] sh_cx, sh_cy;
    logic        [30:0] sh_rad;
    logic        [17:0] sh_cosx, sh_sinx, sh_cosy, sh_siny;

    rsp_pkg::t_in_word  point_queue[$];
    rsp_pkg::t_out_word projection_queue[$];
    int  send_idle_pct = 29, recv_idle_pct = 51;
    int  errors = 0;
    int  quiet_cycles = 0;

    // handshake seen at the last rising edge
    logic o_in_ready_s = 1'b0;

    function automatic longint clip_trig(input logic [17:0] raw);
        longint v;
        v = longint'($signed(raw));
        if (v > rsp_pkg::TRIG_ONE) v = rsp_pkg::TRIG_ONE;
        if (v < -rsp_pkg::TRIG_ONE) v = -rsp_pkg::TRIG_ONE;
        return v;
    endfunction

    function automatic longint rnd_shift(input longint v, input int n);
        longint half;
        half = longint'(1) <<< (n - 1);
        if (v >= 0) return (v + half) >>> n;
        return -((-v + half) >>> n);
    endfunction

    // round(num * 2^30 / den) to nearest, ties away
    function automatic longint sphere_div(input logic [127:0] num,
                                          input logic [127:0] den);
        logic [127:0] q;
        q = ((num << (rsp_pkg::SPHERE_FRAC + 1)) / den + 128'd1) >> 1;
        return longint'(q[62:0]);
    endfunction

    function automatic rsp_pkg::t_out_word project_point(input rsp_pkg::t_in_word p);
        rsp_pkg::t_out_word r;
        longint re, im, are, aim, x, y, z, mz, cxr, sxr, cyr, syr;
        longint rx, fz, ry, rz, offx, offy, sx, sy;
        logic [127:0] r2, one2, den;
        logic ovf;
        r = '0;
        r.batch_end = p.batch_last;
        if (!p.point_finite) return r;
        re  = longint'(p.point_re);
        im  = longint'(p.point_im);
        are = re < 0 ? -re : re;
        aim = im < 0 ? -im : im;
        one2 = 128'd1 << (2 * rsp_pkg::COORD_FRAC_BITS);
        r2  = 128'(are) * 128'(are) + 128'(aim) * 128'(aim);
        den = r2 + one2;
        x = sphere_div(128'(are) << (rsp_pkg::COORD_FRAC_BITS + 1), den);
        y = sphere_div(128'(aim) << (rsp_pkg::COORD_FRAC_BITS + 1), den);
        mz = sphere_div(r2 >= one2 ? r2 - one2 : one2 - r2, den);
        if (re < 0) x = -x;
        if (im < 0) y = -y;
        z = r2 >= one2 ? mz : -mz;
        cxr = clip_trig(sh_cosx); sxr = clip_trig(sh_sinx);
        cyr = clip_trig(sh_cosy); syr = clip_trig(sh_siny);
        rx = rnd_shift(x * cyr + z * syr, rsp_pkg::TRIG_FRAC);
        fz = rnd_shift(z * cyr - x * syr, rsp_pkg::TRIG_FRAC);
        ry = rnd_shift(y * cxr - fz * sxr, rsp_pkg::TRIG_FRAC);
        rz = rnd_shift(y * sxr + fz * cxr, rsp_pkg::TRIG_FRAC);
        offx = rnd_shift(rx * longint'(sh_rad), rsp_pkg::SPHERE_FRAC);
        offy = rnd_shift(ry * longint'(sh_rad), rsp_pkg::SPHERE_FRAC);
        sx = longint'(sh_cx) + offx;
        sy = longint'(sh_cy) - offy;
        ovf = 1'b0;
        if (sx > 64'sd2147483647) begin sx = 64'sd2147483647; ovf = 1'b1; end
        if (sx < -64'sd2147483648) begin sx = -64'sd2147483648; ovf = 1'b1; end
        if (sy > 64'sd2147483647) begin sy = 64'sd2147483647; ovf = 1'b1; end
        if (sy < -64'sd2147483648) begin sy = -64'sd2147483648; ovf = 1'b1; end
        r.screen_x     = sx[31:0];
        r.screen_y     = sy[31:0];
        r.result_valid = !ovf;
        r.front_facing = !ovf && rz >= 0;
        return r;
    endfunction

    // driver: advance on acceptance, idle at random
    always @(negedge i_clk) begin
        if (i_rst_n) begin
            if (!i_in_valid || o_in_ready_s) begin
                if (point_queue.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                    i_in_data  <= point_queue.pop_front();
                    i_in_valid <= 1'b1;
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
            i_out_ready <= $urandom_range(99) >= recv_idle_pct;
        end
    end

    always @(posedge i_clk) o_in_ready_s <= i_in_valid && o_in_ready;

    // monitor: predict on input acceptance, check on output acceptance
    always @(posedge i_clk) begin
        rsp_pkg::t_out_word exp_w;
        if (i_rst_n) begin
            if (i_in_valid && o_in_ready)
                projection_queue.push_back(project_point(i_in_data));
            if (o_out_valid && i_out_ready) begin
                if (projection_queue.size() == 0) begin
                    $display("%0t: unexpected word %h", $time, o_out_data);
                    errors++;
                end else begin
                    exp_w = projection_queue.pop_front();
                    if (exp_w !== o_out_data)
                        $display("%0t: mismatch expected %h actual %h",
                                 $time, exp_w, o_out_data);
                    if (exp_w !== o_out_data) errors++;
                end
            end
            if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
        end
    end

    always @(posedge i_clk) begin
        if (quiet_cycles >= WD_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    task automatic write_reg(input rsp_pkg::t_cfg_idx idx, input logic [31:0] val);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_wdata <= val;
        case (idx)
            rsp_pkg::CFG_CENTER_X: sh_cx   = val;
            rsp_pkg::CFG_CENTER_Y: sh_cy   = val;
            rsp_pkg::CFG_RADIUS:   sh_rad  = val[30:0];
            rsp_pkg::CFG_COS_X:    sh_cosx = val[17:0];
            rsp_pkg::CFG_SIN_X:    sh_sinx = val[17:0];
            rsp_pkg::CFG_COS_Y:    sh_cosy = val[17:0];
            rsp_pkg::CFG_SIN_Y:    sh_siny = val[17:0];
            default: begin
            end
        endcase
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic drain();
        while (point_queue.size() > 0 || i_in_valid || projection_queue.size() > 0)
            @(posedge i_clk);
        repeat (LATENCY + 5) @(posedge i_clk);
    endtask

    function automatic logic [31:0] rand_coord();
        case ($urandom_range(4))
            0: return $urandom;
            1: return 32'($signed($urandom_range(131072)) - 65536);
            2: return 32'($signed($urandom_range(1048576)) - 524288);
            3: return 32'($signed($urandom_range(8192)) - 4096);
            default: return {{8{$urandom_range(1)==1}}, 24'($urandom)};
        endcase
    endfunction

    function automatic logic [31:0] rand_trig();
        if ($urandom_range(9) == 0) return {14'd0, 18'($urandom)};
        return {14'd0, 18'($signed($urandom_range(131072)) - 65536)};
    endfunction

    task automatic add_point(input logic [31:0] re, input logic [31:0] im,
                             input logic fin, input logic last);
        rsp_pkg::t_in_word w;
        w.point_re = re; w.point_im = im; w.point_finite = fin; w.batch_last = last;
        point_queue.push_back(w);
    endtask

    task automatic random_points(input int n);
        repeat (n)
            add_point(rand_coord(), rand_coord(), $urandom_range(15) != 0,
                      $urandom_range(7) == 0);
    endtask

    task automatic random_config();
        write_reg(rsp_pkg::CFG_CENTER_X, $urandom_range(3) == 0 ? $urandom
                                 : 32'($signed($urandom_range(2000000)) - 1000000));
        write_reg(rsp_pkg::CFG_CENTER_Y, $urandom_range(3) == 0 ? $urandom
                                 : 32'($signed($urandom_range(2000000)) - 1000000));
        write_reg(rsp_pkg::CFG_RADIUS, $urandom_range(3) == 0 ? {1'b0, 31'($urandom)}
                               : $urandom_range(1 << 24));
        write_reg(rsp_pkg::CFG_COS_X, rand_trig());
        write_reg(rsp_pkg::CFG_SIN_X, rand_trig());
        write_reg(rsp_pkg::CFG_COS_Y, rand_trig());
        write_reg(rsp_pkg::CFG_SIN_Y, rand_trig());
    endtask

    initial begin
        sh_cx = '0; sh_cy = '0; sh_rad = 31'd65536;
        sh_cosx = 18'd65536; sh_sinx = '0; sh_cosy = 18'd65536; sh_siny = '0;
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed: origin, unit circle, extremes, non-finite, batch mark
        add_point(32'h0, 32'h0, 1'b1, 1'b0);
        add_point(32'h0001_0000, 32'h0, 1'b1, 1'b0);
        add_point(32'h0, 32'hFFFF_0000, 1'b1, 1'b1);
        add_point(32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b1, 1'b0);
        add_point(32'h8000_0000, 32'h8000_0000, 1'b1, 1'b0);
        add_point(32'h8000_0000, 32'h7FFF_FFFF, 1'b1, 1'b1);
        add_point(32'h0000_0001, 32'hFFFF_FFFF, 1'b1, 1'b0);
        add_point(32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0, 1'b1);
        add_point(32'h0000_8000, 32'h0000_8000, 1'b1, 1'b0);
        drain();

        // radius and center extremes, trig over range, quarter turns
        write_reg(rsp_pkg::CFG_RADIUS, 32'h7FFF_FFFF);
        write_reg(rsp_pkg::CFG_CENTER_X, 32'h7FFF_0000);
        write_reg(rsp_pkg::CFG_CENTER_Y, 32'h8000_0000);
        write_reg(rsp_pkg::CFG_COS_X, 32'h0001_FFFF);
        write_reg(rsp_pkg::CFG_SIN_X, 32'h0002_0000);
        write_reg(rsp_pkg::CFG_COS_Y, 32'h0);
        write_reg(rsp_pkg::CFG_SIN_Y, 32'h0003_0000);
        add_point(32'h0, 32'h0, 1'b1, 1'b0);
        add_point(32'h0001_0000, 32'h0001_0000, 1'b1, 1'b0);
        add_point(32'hFFFF_0000, 32'h0000_4000, 1'b1, 1'b1);
        add_point(32'h7FFF_FFFF, 32'h8000_0000, 1'b1, 1'b0);
        add_point(32'h1234_5678, 32'h8765_4321, 1'b0, 1'b0);
        drain();
        write_reg(rsp_pkg::CFG_RADIUS, 32'h0);
        write_reg(rsp_pkg::CFG_CENTER_X, 32'h8000_0000);
        write_reg(rsp_pkg::CFG_CENTER_Y, 32'h7FFF_FFFF);
        write_reg(rsp_pkg::CFG_COS_X, 32'h0001_0000);
        write_reg(rsp_pkg::CFG_SIN_X, 32'h0);
        add_point(32'h0003_0000, 32'hFFFD_0000, 1'b1, 1'b0);
        add_point(32'h0, 32'h0, 1'b1, 1'b1);
        drain();
        write_reg(rsp_pkg::CFG_RADIUS, 32'h1);
        write_reg(rsp_pkg::CFG_COS_Y, 32'h0003_0000);
        write_reg(rsp_pkg::CFG_SIN_Y, 32'h0001_0000);
        add_point(32'h0000_4000, 32'h0002_0000, 1'b1, 1'b0);
        drain();

        for (int ph = 0; ph < 6; ph++) begin
            if (ph < 2)      begin send_idle_pct = 29; recv_idle_pct = 51; end
            else if (ph < 4) begin send_idle_pct = 51; recv_idle_pct = 29; end
            else             begin send_idle_pct = 0;  recv_idle_pct = 0;  end
            random_config();
            random_points(N_RANDOM / 6);
            drain();
        end

        if (errors == 0 && projection_queue.size() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end
endmodule
